@@ src/i2cmbe_pkg.sv @@
// shared types, codes and reset constants for the i2c master bit engine
// no dependencies; imported by every module of the block

package i2cmbe_pkg;

    // configuration register reset values
    localparam logic [15:0] PHASE_TICKS_RST     = 16'd5;
    localparam logic [15:0] STRETCH_TIMEOUT_RST = 16'd300;
    localparam logic [7:0]  LOW_CHECK_TICKS_RST = 8'd1;

    // apb register map, word index taken from paddr[3:2]
    localparam int unsigned ADDR_W = 4;

    typedef enum logic [1:0] {
        REG_PHASE_TICKS     = 2'd0,
        REG_STRETCH_TIMEOUT = 2'd1,
        REG_LOW_CHECK_TICKS = 2'd2,
        REG_UNUSED          = 2'd3
    } reg_idx_t;

    // bus commands
    typedef enum logic [2:0] {
        CMD_NONE  = 3'd0,
        CMD_START = 3'd1,
        CMD_STOP  = 3'd2,
        CMD_WRITE = 3'd3,
        CMD_READ  = 3'd4,
        CMD_RSV5  = 3'd5,
        CMD_RSV6  = 3'd6,
        CMD_RSV7  = 3'd7
    } cmd_t;

    // sequencer phases
    typedef enum logic [3:0] {
        PH_IDLE    = 4'd0,
        PH_S_LCHK1 = 4'd1,
        PH_S_LOW   = 4'd2,
        PH_S_HCHK  = 4'd3,
        PH_S_SETUP = 4'd4,
        PH_S_HOLD  = 4'd5,
        PH_S_LCHK2 = 4'd6,
        PH_P_LOW   = 4'd7,
        PH_P_HCHK  = 4'd8,
        PH_P_SETUP = 4'd9,
        PH_P_BUF   = 4'd10,
        PH_B_LOW   = 4'd11,
        PH_B_HCHK  = 4'd12,
        PH_B_HIGH  = 4'd13,
        PH_B_LCHK  = 4'd14
    } phase_t;

    // configuration seen by the sequencer
    typedef struct packed {
        logic [15:0] phase_ticks;
        logic [15:0] stretch_timeout;
        logic [7:0]  low_check_ticks;
    } cfg_t;

    // one input word
    typedef struct packed {
        cmd_t       command;
        logic [7:0] write_byte;
        logic       send_ack;
        logic       scl_level;
        logic       sda_level;
    } tick_t;

    // one result word
    typedef struct packed {
        logic       scl_released;
        logic       sda_released;
        logic       busy_res;
        logic       done_res;
        logic       ack_seen;
        logic [7:0] read_byte;
        logic       timeout_error;
    } res_t;

    // a zero register value acts as one
    function automatic logic [15:0] at_least_one(input logic [15:0] v);
        at_least_one = (v == 16'd0) ? 16'd1 : v;
    endfunction

endpackage

@@ src/i2cmbe_regs.sv @@
// apb configuration registers for the i2c master bit engine
// depends on i2cmbe_pkg

module i2cmbe_regs (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [i2cmbe_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready,
    output i2cmbe_pkg::cfg_t               cfg
);
    import i2cmbe_pkg::*;

    logic [15:0] phase_ticks_reg;
    logic [15:0] stretch_timeout_reg;
    logic [7:0]  low_check_ticks_reg;
    logic        wr_en;
    reg_idx_t    idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign idx    = reg_idx_t'(paddr[3:2]);

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_ticks_reg     <= PHASE_TICKS_RST;
            stretch_timeout_reg <= STRETCH_TIMEOUT_RST;
            low_check_ticks_reg <= LOW_CHECK_TICKS_RST;
        end
        else if (wr_en)
        begin
            unique case (idx)
                REG_PHASE_TICKS:     phase_ticks_reg     <= pwdata[15:0];
                REG_STRETCH_TIMEOUT: stretch_timeout_reg <= pwdata[15:0];
                REG_LOW_CHECK_TICKS: low_check_ticks_reg <= pwdata[7:0];
                default:             ;
            endcase
        end
    end

    // read back
    always_comb
    begin
        prdata = 32'd0;
        unique case (idx)
            REG_PHASE_TICKS:     prdata = {16'd0, phase_ticks_reg};
            REG_STRETCH_TIMEOUT: prdata = {16'd0, stretch_timeout_reg};
            REG_LOW_CHECK_TICKS: prdata = {24'd0, low_check_ticks_reg};
            default:             prdata = 32'd0;
        endcase
    end

    assign cfg.phase_ticks     = phase_ticks_reg;
    assign cfg.stretch_timeout = stretch_timeout_reg;
    assign cfg.low_check_ticks = low_check_ticks_reg;

endmodule

@@ src/i2cmbe_seq.sv @@
// i2c line sequencer: state registers and one-tick next-state logic
// depends on i2cmbe_pkg

module i2cmbe_seq (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step,
    input  i2cmbe_pkg::cfg_t   cfg,
    input  i2cmbe_pkg::tick_t  tick,
    output i2cmbe_pkg::res_t   res
);
    import i2cmbe_pkg::*;

    phase_t      phase_reg, phase_next;
    cmd_t        cmd_reg, cmd_next;
    logic [3:0]  bit_cnt_reg, bit_cnt_next;
    logic [7:0]  shift_reg, shift_next;
    logic [15:0] wait_reg, wait_next;
    logic        scl_reg, scl_next;
    logic        sda_reg, sda_next;
    logic        ack_choice_reg, ack_choice_next;
    logic        ack_flag_reg, ack_flag_next;
    logic        err_reg, err_next;
    logic [7:0]  read_hold_reg, read_hold_next;
    logic        done;

    logic [15:0] wait_inc;
    logic [15:0] eff_phase;
    logic [15:0] eff_stretch;
    logic [15:0] eff_low;
    logic        delay_done;
    logic        hchk_to;
    logic        lchk_to;
    logic [3:0]  bit_inc;
    logic [7:0]  shift_left;

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            cmd_reg        <= CMD_NONE;
            bit_cnt_reg    <= 4'd0;
            shift_reg      <= 8'd0;
            wait_reg       <= 16'd0;
            scl_reg        <= 1'b1;
            sda_reg        <= 1'b1;
            ack_choice_reg <= 1'b0;
            ack_flag_reg   <= 1'b0;
            err_reg        <= 1'b0;
            read_hold_reg  <= 8'd0;
        end
        else if (step)
        begin
            phase_reg      <= phase_next;
            cmd_reg        <= cmd_next;
            bit_cnt_reg    <= bit_cnt_next;
            shift_reg      <= shift_next;
            wait_reg       <= wait_next;
            scl_reg        <= scl_next;
            sda_reg        <= sda_next;
            ack_choice_reg <= ack_choice_next;
            ack_flag_reg   <= ack_flag_next;
            err_reg        <= err_next;
            read_hold_reg  <= read_hold_next;
        end
    end

    // shared counters and limit compares
    assign wait_inc    = wait_reg + 16'd1;
    assign eff_phase   = at_least_one(cfg.phase_ticks);
    assign eff_stretch = at_least_one(cfg.stretch_timeout);
    assign eff_low     = at_least_one({8'd0, cfg.low_check_ticks});
    assign delay_done  = (wait_inc >= eff_phase);
    assign hchk_to     = (wait_inc >= eff_stretch);
    assign lchk_to     = (wait_inc >= eff_low);
    assign bit_inc     = bit_cnt_reg + 4'd1;
    assign shift_left  = {shift_reg[6:0], 1'b0};

    // next state and outputs for one tick
    always_comb
    begin
        phase_next      = phase_reg;
        cmd_next        = cmd_reg;
        bit_cnt_next    = bit_cnt_reg;
        shift_next      = shift_reg;
        wait_next       = wait_reg;
        scl_next        = scl_reg;
        sda_next        = sda_reg;
        ack_choice_next = ack_choice_reg;
        ack_flag_next   = ack_flag_reg;
        err_next        = err_reg;
        read_hold_next  = read_hold_reg;
        done            = 1'b0;

        unique case (phase_reg)
            PH_IDLE:
            begin
                if ((tick.command == CMD_START) || (tick.command == CMD_STOP) ||
                    (tick.command == CMD_WRITE) || (tick.command == CMD_READ))
                begin
                    cmd_next      = tick.command;
                    wait_next     = 16'd0;
                    bit_cnt_next  = 4'd0;
                    ack_flag_next = 1'b0;
                    err_next      = 1'b0;
                    unique case (tick.command)
                        CMD_START:
                        begin
                            scl_next   = 1'b0;
                            phase_next = PH_S_LCHK1;
                        end
                        CMD_STOP:
                        begin
                            sda_next   = 1'b0;
                            phase_next = PH_P_LOW;
                        end
                        CMD_WRITE:
                        begin
                            shift_next = tick.write_byte;
                            sda_next   = tick.write_byte[7];
                            phase_next = PH_B_LOW;
                        end
                        default:
                        begin
                            shift_next      = 8'd0;
                            ack_choice_next = tick.send_ack;
                            sda_next        = 1'b1;
                            phase_next      = PH_B_LOW;
                        end
                    endcase
                end
            end

            // start condition
            PH_S_LCHK1:
            begin
                if (!tick.scl_level || lchk_to)
                begin
                    wait_next  = 16'd0;
                    sda_next   = 1'b1;
                    phase_next = PH_S_LOW;
                end
                else
                    wait_next = wait_inc;
            end
            PH_S_LOW:
            begin
                wait_next = delay_done ? 16'd0 : wait_inc;
                if (delay_done)
                begin
                    scl_next   = 1'b1;
                    phase_next = PH_S_HCHK;
                end
            end
            PH_S_HCHK:
            begin
                if (tick.scl_level || hchk_to)
                begin
                    wait_next  = 16'd0;
                    phase_next = PH_S_SETUP;
                end
                else
                    wait_next = wait_inc;
            end
            PH_S_SETUP:
            begin
                wait_next = delay_done ? 16'd0 : wait_inc;
                if (delay_done)
                begin
                    sda_next   = 1'b0;
                    phase_next = PH_S_HOLD;
                end
            end
            PH_S_HOLD:
            begin
                wait_next = delay_done ? 16'd0 : wait_inc;
                if (delay_done)
                begin
                    scl_next   = 1'b0;
                    phase_next = PH_S_LCHK2;
                end
            end
            PH_S_LCHK2:
            begin
                if (!tick.scl_level || lchk_to)
                begin
                    wait_next  = 16'd0;
                    done       = 1'b1;
                    phase_next = PH_IDLE;
                end
                else
                    wait_next = wait_inc;
            end

            // stop condition
            PH_P_LOW:
            begin
                wait_next = delay_done ? 16'd0 : wait_inc;
                if (delay_done)
                begin
                    scl_next   = 1'b1;
                    phase_next = PH_P_HCHK;
                end
            end
            PH_P_HCHK:
            begin
                if (tick.scl_level || hchk_to)
                begin
                    wait_next  = 16'd0;
                    phase_next = PH_P_SETUP;
                end
                else
                    wait_next = wait_inc;
            end
            PH_P_SETUP:
            begin
                wait_next = delay_done ? 16'd0 : wait_inc;
                if (delay_done)
                begin
                    sda_next   = 1'b1;
                    phase_next = PH_P_BUF;
                end
            end
            PH_P_BUF:
            begin
                wait_next = delay_done ? 16'd0 : wait_inc;
                if (delay_done)
                begin
                    done       = 1'b1;
                    phase_next = PH_IDLE;
                end
            end

            // byte transfer, one bit per low/high cycle
            PH_B_LOW:
            begin
                wait_next = delay_done ? 16'd0 : wait_inc;
                if (delay_done)
                begin
                    scl_next   = 1'b1;
                    phase_next = PH_B_HCHK;
                end
            end
            PH_B_HCHK:
            begin
                if (tick.scl_level)
                begin
                    wait_next  = 16'd0;
                    phase_next = PH_B_HIGH;
                end
                else if (hchk_to)
                begin
                    wait_next  = 16'd0;
                    err_next   = 1'b1;
                    done       = 1'b1;
                    phase_next = PH_IDLE;
                end
                else
                    wait_next = wait_inc;
            end
            PH_B_HIGH:
            begin
                wait_next = delay_done ? 16'd0 : wait_inc;
                if (delay_done)
                begin
                    if ((cmd_reg == CMD_READ) && (bit_cnt_reg < 4'd8))
                        shift_next = {shift_reg[6:0], tick.sda_level};
                    if ((cmd_reg == CMD_WRITE) && (bit_cnt_reg == 4'd8))
                        ack_flag_next = !tick.sda_level;
                    scl_next   = 1'b0;
                    phase_next = PH_B_LCHK;
                end
            end
            PH_B_LCHK:
            begin
                if (!tick.scl_level)
                begin
                    wait_next    = 16'd0;
                    bit_cnt_next = bit_inc;
                    if (bit_inc >= 4'd9)
                    begin
                        if (cmd_reg == CMD_READ)
                            read_hold_next = shift_reg;
                        done       = 1'b1;
                        phase_next = PH_IDLE;
                    end
                    else
                    begin
                        if (cmd_reg == CMD_WRITE)
                        begin
                            shift_next = shift_left;
                            sda_next   = (bit_inc < 4'd8) ? shift_left[7] : 1'b1;
                        end
                        else
                            sda_next = (bit_inc < 4'd8) ? 1'b1 : !ack_choice_reg;
                        phase_next = PH_B_LOW;
                    end
                end
                else if (lchk_to)
                begin
                    wait_next  = 16'd0;
                    err_next   = 1'b1;
                    done       = 1'b1;
                    phase_next = PH_IDLE;
                end
                else
                    wait_next = wait_inc;
            end

            default:
            begin
                phase_next = PH_IDLE;
                wait_next  = 16'd0;
            end
        endcase
    end

    // result word for this tick
    assign res.scl_released  = scl_next;
    assign res.sda_released  = sda_next;
    assign res.busy_res      = (phase_next != PH_IDLE);
    assign res.done_res      = done;
    assign res.ack_seen      = ack_flag_next;
    assign res.read_byte     = read_hold_next;
    assign res.timeout_error = err_next;

endmodule

@@ src/i2c_master_bit_engine_unit.sv @@
// i2c master bit engine: an accepted input word has its result word registered in
// the output register; throughput one word per cycle while it is free or draining,
// the sequencer state advancing once per accepted word.
// the output register frees for a new word in the cycle it is taken.
// reset: sequencer idle, both lines released, flags and read byte zero,
// configuration registers back to 5, 300 and 1; no result word pending.

// top level: apb config, sequencer and output register
// depends on i2cmbe_pkg, i2cmbe_regs, i2cmbe_seq

module i2c_master_bit_engine_unit (
    input  logic                           clk,
    input  logic                           rst_n,
    // input stream
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // [2:0] command, [10:3] write_byte, [11] send_ack, [12] scl_level,
    // [13] sda_level, [15:14] zero
    input  logic [15:0]                    s_tdata,
    // result stream
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [0] scl_released, [1] sda_released, [2] busy_res, [3] done_res,
    // [4] ack_seen, [12:5] read_byte, [13] timeout_error, [15:14] zero
    output logic [15:0]                    m_tdata,
    // configuration port
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [i2cmbe_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);
    import i2cmbe_pkg::*;

    cfg_t        cfg;
    tick_t       tick;
    res_t        res;
    logic        accept;
    logic        m_tvalid_reg, m_tvalid_next;
    logic [15:0] m_tdata_reg;

    i2cmbe_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // unpack input word
    assign tick.command    = cmd_t'(s_tdata[2:0]);
    assign tick.write_byte = s_tdata[10:3];
    assign tick.send_ack   = s_tdata[11];
    assign tick.scl_level  = s_tdata[12];
    assign tick.sda_level  = s_tdata[13];

    // handshake: take a word whenever the output register is free or draining
    assign s_tready = !m_tvalid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    i2cmbe_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (accept),
        .cfg   (cfg),
        .tick  (tick),
        .res   (res)
    );

    // output valid
    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        if (accept)
            m_tvalid_next = 1'b1;
        else if (m_tready)
            m_tvalid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tvalid_reg <= 1'b0;
        else
            m_tvalid_reg <= m_tvalid_next;
    end

    // output data
    always_ff @(posedge clk)
    begin
        if (accept)
            m_tdata_reg <= {2'b00, res.timeout_error, res.read_byte, res.ack_seen,
                            res.done_res, res.busy_res, res.sda_released,
                            res.scl_released};
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule
